// File: sv/chol_pkg.sv
// ============================================================================
// chol_pkg: shared codes, sizes and command types
// Request, status and register codes plus the command and status bundles
// passed between the controller and the datapath.
// ============================================================================
package chol_pkg;

   // default sizes
   localparam int MAX_ORDER_DEF  = 8;
   localparam int DATA_WIDTH_DEF = 32;

   // fixed port widths
   localparam int FIELD_W    = 32;
   localparam int ROW_W      = 3;
   localparam int REQ_W      = 2;
   localparam int STATUS_W   = 2;
   localparam int SIZE_W     = 4;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 4;

   // fixed point
   localparam int Q_FRAC    = 16;
   localparam int Q_ONE_INT = 65536;

   // request codes
   localparam logic [REQ_W-1:0] REQ_LOAD    = 2'd0;
   localparam logic [REQ_W-1:0] REQ_COMPUTE = 2'd1;
   localparam logic [REQ_W-1:0] REQ_READ    = 2'd2;
   localparam logic [REQ_W-1:0] REQ_NOP     = 2'd3;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOT_POS  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_ZERO_DIV = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MATRIX_SIZE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_COMPUTE_INV = 1'b1;
   localparam logic [SIZE_W-1:0]    SIZE_RESET      = 4'd8;

   // controller to datapath commands
   typedef struct packed {
      logic                in_we;
      logic                fac_we;
      logic                fac_zero;
      logic                fac_from_sqrt;
      logic                inv_we;
      logic                inv_zero;
      logic                acc_clr;
      logic                mul_en;
      logic                mul_inv;
      logic                acc_en;
      logic                fin_fac;
      logic                fin_inv;
      logic                fin_diag;
      logic                sqrt_start;
      logic                div_start;
      logic                rd_capture;
      logic                rd_ok;
      logic                rsp_zero;
      logic                rsp_read;
      logic                status_we;
      logic [STATUS_W-1:0] status_code;
   } dp_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic d_le0;
      logic piv_zero;
      logic sqrt_done;
      logic div_done;
   } dp_sts_type;

endpackage

// File: sv/cholesky_factor_and_inverse.sv
// ============================================================================
// cholesky_factor_and_inverse: Cholesky factor and triangular inverse
// Top level joining the sequencer and the datapath.
// ============================================================================
// Load and no-op requests give their result on the cycle after the transfer;
// a read first passes through a wait state that loads the result register.
// A compute request holds the input channel until it ends: each product of
// an inner sum steps through read, multiply and accumulate states on two
// store read ports, each diagonal entry waits on a square root (one root bit
// a cycle), and each lower off-diagonal entry and each lower inverse entry
// waits on a divide (one quotient bit a cycle), after entry, read, finish and
// check states. For order n that is roughly n^3/3 products plus n^2 divides
// and n square roots. Configuration must be written only while no request is
// in flight; the block does not enforce it. There is no clearing pass after reset.
// ============================================================================
module cholesky_factor_and_inverse import chol_pkg::*; #(
   parameter int MAX_ORDER  = MAX_ORDER_DEF,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [REQ_W-1:0]          req_type,
   input  logic [ROW_W-1:0]          req_row,
   input  logic [ROW_W-1:0]          req_col,
   input  logic signed [FIELD_W-1:0] req_value,
   input  logic                      req_which_matrix,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [FIELD_W-1:0] rsp_result_value,
   output logic [STATUS_W-1:0]       rsp_status,
   input  logic                      csr_write_en,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_data
);

   localparam int IW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;

   dp_cmd_type    cmd;
   dp_sts_type    sts;
   logic [IW-1:0] fa_row, fa_col, fb_row, fb_col, iv_row, iv_col, wr_row, wr_col;

   chol_ctrl #(.MAX_ORDER(MAX_ORDER)) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_type     (req_type),
      .req_row      (req_row),
      .req_col      (req_col),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .sts          (sts),
      .cmd          (cmd),
      .fa_row       (fa_row),
      .fa_col       (fa_col),
      .fb_row       (fb_row),
      .fb_col       (fb_col),
      .iv_row       (iv_row),
      .iv_col       (iv_col),
      .wr_row       (wr_row),
      .wr_col       (wr_col)
   );

   chol_datapath #(.MAX_ORDER(MAX_ORDER), .DATA_WIDTH(DATA_WIDTH)) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .fa_row           (fa_row),
      .fa_col           (fa_col),
      .fb_row           (fb_row),
      .fb_col           (fb_col),
      .iv_row           (iv_row),
      .iv_col           (iv_col),
      .wr_row           (wr_row),
      .wr_col           (wr_col),
      .req_value        (req_value),
      .req_which_matrix (req_which_matrix),
      .rsp_result_value (rsp_result_value),
      .rsp_status       (rsp_status)
   );

   // load and no-op results follow the transfer directly
   a_load_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && (req_type == REQ_LOAD || req_type == REQ_NOP))
      |=> rsp_valid)
      else $error("load result missing");

   // a read answers after a wait state that follows its transfer
   a_read_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_type == REQ_READ) |=> !rsp_valid ##1 rsp_valid)
      else $error("read result timing");

   // a compute result never shows on the next cycle
   a_compute_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_type == REQ_COMPUTE) |=> !rsp_valid)
      else $error("compute result too early");

   // status carries only defined codes
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == ST_OK || rsp_status == ST_NOT_POS ||
                     rsp_status == ST_ZERO_DIV))
      else $error("undefined status code");

endmodule

// File: sv/chol_sqrt.sv
// ============================================================================
// chol_sqrt: bit-serial floor square root
// Returns floor(sqrt(arg * 2^16)) one root bit per cycle, saturated to the
// signed range of the word.
// ============================================================================
module chol_sqrt import chol_pkg::*; #(
   parameter int WW = DATA_WIDTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [WW-1:0]        arg,
   output logic                 done,
   output logic signed [WW-1:0] root
);

   localparam int SX  = ((WW + Q_FRAC + 1) / 2) * 2;
   localparam int RW  = SX / 2;
   localparam int CNW = $clog2(RW + 1);
   localparam int CW  = RW + WW;

   logic           busy_ff, busy_in;
   logic           done_ff, done_in;
   logic [CNW-1:0] cnt_ff, cnt_in;
   logic [SX-1:0]  x_ff;
   logic [RW:0]    rem_ff;
   logic [RW-1:0]  root_ff;
   logic [RW+2:0]  rem_t;
   logic [RW+2:0]  trial;
   logic           ge;
   logic [CW-1:0]  root_w;
   logic [CW-1:0]  qmax_c;

   // one trial subtraction per cycle
   assign rem_t = {rem_ff, x_ff[SX-1 -: 2]};
   assign trial = {1'b0, root_ff, 2'b01};
   assign ge    = rem_t >= trial;

   // control
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
      end else if (busy_ff) begin
         if (cnt_ff == CNW'(RW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff + CNW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // remainder and root
   always_ff @(posedge clock) begin
      if (start) begin
         x_ff    <= SX'({arg, {Q_FRAC{1'b0}}});
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         x_ff    <= {x_ff[SX-3:0], 2'b00};
         rem_ff  <= ge ? rem_t[RW:0] - trial[RW:0] : rem_t[RW:0];
         root_ff <= {root_ff[RW-2:0], ge};
      end
   end

   // saturate to the signed range
   assign root_w = CW'(root_ff);
   assign qmax_c = CW'({(WW-1){1'b1}});
   assign root   = (root_w > qmax_c) ? WW'(qmax_c) : WW'(root_w);
   assign done   = done_ff;

endmodule

// File: sv/chol_div.sv
// ============================================================================
// chol_div: restoring fixed-point divider
// Computes (num * 2^16) / den truncated toward zero, one quotient bit per
// cycle, saturated to the signed range of the word.
// ============================================================================
module chol_div import chol_pkg::*; #(
   parameter int WW = DATA_WIDTH_DEF,
   parameter int DW = DATA_WIDTH_DEF + 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic signed [DW-1:0] num,
   input  logic signed [WW-1:0] den,
   output logic                 done,
   output logic signed [WW-1:0] quo
);

   localparam int NW  = DW + Q_FRAC;
   localparam int CNW = $clog2(NW + 1);

   logic           busy_ff, busy_in;
   logic           done_ff, done_in;
   logic [CNW-1:0] cnt_ff, cnt_in;
   logic [NW-1:0]  n_ff;
   logic [WW:0]    rem_ff;
   logic [WW-1:0]  dmag_ff;
   logic           neg_ff;
   logic [DW-1:0]  nmag;
   logic [WW:0]    rem_t;
   logic           ge;
   logic [NW-1:0]  qmax_n;
   logic [NW-1:0]  qmin_mag;
   logic [WW-1:0]  qmax_w;

   assign nmag  = num[DW-1] ? DW'(-num) : DW'(num);
   assign rem_t = {rem_ff[WW-1:0], n_ff[NW-1]};
   assign ge    = rem_t >= {1'b0, dmag_ff};

   // control
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
      end else if (busy_ff) begin
         if (cnt_ff == CNW'(NW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff + CNW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // shift-subtract on magnitudes; quotient shifts in at the bottom
   always_ff @(posedge clock) begin
      if (start) begin
         n_ff    <= {nmag, {Q_FRAC{1'b0}}};
         rem_ff  <= '0;
         dmag_ff <= den[WW-1] ? WW'(-den) : WW'(den);
         neg_ff  <= num[DW-1] ^ den[WW-1];
      end else if (busy_ff) begin
         rem_ff <= ge ? rem_t - {1'b0, dmag_ff} : rem_t;
         n_ff   <= {n_ff[NW-2:0], ge};
      end
   end

   // sign and saturation
   assign qmax_w   = {1'b0, {(WW-1){1'b1}}};
   assign qmax_n   = NW'(qmax_w);
   assign qmin_mag = NW'(1) << (WW - 1);

   always_comb begin
      if (!neg_ff) begin
         quo = (n_ff > qmax_n) ? qmax_w : n_ff[WW-1:0];
      end else begin
         quo = (n_ff > qmin_mag) ? ~qmax_w : -(n_ff[WW-1:0]);
      end
   end

   assign done = done_ff;

endmodule

// File: sv/chol_datapath.sv
// ============================================================================
// chol_datapath: stores, multiply-accumulate and result registers
// Holds the input, factor and inverse stores, the saturating MAC, the square
// root and divide units, last status and the result register.
// ============================================================================
module chol_datapath import chol_pkg::*; #(
   parameter int MAX_ORDER  = MAX_ORDER_DEF,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF,
   localparam int IW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  dp_cmd_type                 cmd,
   output dp_sts_type                 sts,
   input  logic [IW-1:0]              fa_row,
   input  logic [IW-1:0]              fa_col,
   input  logic [IW-1:0]              fb_row,
   input  logic [IW-1:0]              fb_col,
   input  logic [IW-1:0]              iv_row,
   input  logic [IW-1:0]              iv_col,
   input  logic [IW-1:0]              wr_row,
   input  logic [IW-1:0]              wr_col,
   input  logic signed [FIELD_W-1:0]  req_value,
   input  logic                       req_which_matrix,
   output logic signed [FIELD_W-1:0]  rsp_result_value,
   output logic [STATUS_W-1:0]        rsp_status
);

   localparam int WW    = (DATA_WIDTH > 32) ? 32 : DATA_WIDTH;
   localparam int DW    = WW + 2;
   localparam int LW    = 2 * WW + 18;
   localparam int DEPTH = MAX_ORDER * MAX_ORDER;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic signed [LW-1:0] QMAX_L = {{(LW-WW+1){1'b0}}, {(WW-1){1'b1}}};
   localparam logic signed [LW-1:0] QMIN_L = ~QMAX_L;

   function automatic logic signed [WW-1:0] sat(input logic signed [LW-1:0] v);
      logic signed [WW-1:0] r;
      if (v > QMAX_L) begin
         r = QMAX_L[WW-1:0];
      end else if (v < QMIN_L) begin
         r = QMIN_L[WW-1:0];
      end else begin
         r = v[WW-1:0];
      end
      return r;
   endfunction

   function automatic logic [AW-1:0] addr(input logic [IW-1:0] r, input logic [IW-1:0] c);
      return AW'(int'(r) * MAX_ORDER + int'(c));
   endfunction

   logic signed [WW-1:0]      in_mem  [DEPTH];
   logic signed [WW-1:0]      fac_mem [DEPTH];
   logic signed [WW-1:0]      inv_mem [DEPTH];

   logic signed [WW-1:0]      in_rd_ff, fa_rd_ff, fb_rd_ff, iv_rd_ff;
   logic signed [2*WW-1:0]    prod_ff;
   logic signed [WW-1:0]      acc_ff;
   logic signed [DW-1:0]      d_ff;
   logic signed [WW-1:0]      piv_ff;
   logic                      rd_ok_ff, which_ff;
   logic [STATUS_W-1:0]       status_ff, status_in;
   logic signed [FIELD_W-1:0] rsp_value_ff;
   logic [STATUS_W-1:0]       rsp_status_ff;

   logic signed [WW-1:0]      mq;
   logic signed [WW-1:0]      sqrt_q, div_q;
   logic                      sqrt_done, div_done;
   logic signed [WW-1:0]      fac_wdata, inv_wdata;

   // stores: one write port each, registered reads
   assign fac_wdata = cmd.fac_zero ? '0 : (cmd.fac_from_sqrt ? sqrt_q : div_q);
   assign inv_wdata = cmd.inv_zero ? '0 : div_q;

   always_ff @(posedge clock) begin
      if (cmd.in_we) begin
         in_mem[addr(wr_row, wr_col)] <= sat(LW'(req_value));
      end
      if (cmd.fac_we) begin
         fac_mem[addr(wr_row, wr_col)] <= fac_wdata;
      end
      if (cmd.inv_we) begin
         inv_mem[addr(wr_row, wr_col)] <= inv_wdata;
      end
      in_rd_ff <= in_mem[addr(wr_row, wr_col)];
      fa_rd_ff <= fac_mem[addr(fa_row, fa_col)];
      fb_rd_ff <= fac_mem[addr(fb_row, fb_col)];
      iv_rd_ff <= inv_mem[addr(iv_row, iv_col)];
   end

   // saturating multiply-accumulate
   assign mq = sat(LW'(prod_ff >>> Q_FRAC));

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff <= fa_rd_ff * (cmd.mul_inv ? iv_rd_ff : fb_rd_ff);
      end
      if (cmd.acc_clr) begin
         acc_ff <= '0;
      end else if (cmd.acc_en) begin
         acc_ff <= sat(LW'(acc_ff) + LW'(mq));
      end
   end

   // operands for the square root and divide units
   always_ff @(posedge clock) begin
      if (cmd.fin_fac) begin
         d_ff   <= DW'(sat(LW'(in_rd_ff) - LW'(acc_ff)));
         piv_ff <= fb_rd_ff;
      end else if (cmd.fin_inv) begin
         d_ff   <= cmd.fin_diag ? DW'(Q_ONE_INT) : DW'(sat(-LW'(acc_ff)));
         piv_ff <= fb_rd_ff;
      end
   end

   chol_sqrt #(.WW(WW)) u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (cmd.sqrt_start),
      .arg   (d_ff[WW-1:0]),
      .done  (sqrt_done),
      .root  (sqrt_q)
   );

   chol_div #(.WW(WW), .DW(DW)) u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (d_ff),
      .den   (piv_ff),
      .done  (div_done),
      .quo   (div_q)
   );

   assign sts.d_le0     = d_ff <= 0;
   assign sts.piv_zero  = piv_ff == 0;
   assign sts.sqrt_done = sqrt_done;
   assign sts.div_done  = div_done;

   // last status
   assign status_in = cmd.status_we ? cmd.status_code : status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff <= ST_OK;
      end else begin
         status_ff <= status_in;
      end
   end

   // read bookkeeping and result register
   always_ff @(posedge clock) begin
      if (cmd.rd_capture) begin
         rd_ok_ff <= cmd.rd_ok;
         which_ff <= req_which_matrix;
      end
      if (cmd.rsp_zero) begin
         rsp_value_ff  <= '0;
         rsp_status_ff <= status_in;
      end else if (cmd.rsp_read) begin
         rsp_value_ff  <= rd_ok_ff ? FIELD_W'(which_ff ? iv_rd_ff : fa_rd_ff) : '0;
         rsp_status_ff <= status_ff;
      end
   end

   assign rsp_result_value = rsp_value_ff;
   assign rsp_status       = rsp_status_ff;

endmodule

// File: sv/chol_ctrl.sv
// ============================================================================
// chol_ctrl: request handling and factorization sequencer
// Holds the configuration registers, the handshake, and the row, column and
// inner-product counters that step the datapath through both phases.
// ============================================================================
module chol_ctrl import chol_pkg::*; #(
   parameter int MAX_ORDER = MAX_ORDER_DEF,
   localparam int IW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [REQ_W-1:0]      req_type,
   input  logic [ROW_W-1:0]      req_row,
   input  logic [ROW_W-1:0]      req_col,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  dp_sts_type            sts,
   output dp_cmd_type            cmd,
   output logic [IW-1:0]         fa_row,
   output logic [IW-1:0]         fa_col,
   output logic [IW-1:0]         fb_row,
   output logic [IW-1:0]         fb_col,
   output logic [IW-1:0]         iv_row,
   output logic [IW-1:0]         iv_col,
   output logic [IW-1:0]         wr_row,
   output logic [IW-1:0]         wr_col
);

   localparam logic [4:0] S_IDLE    = 5'd0;
   localparam logic [4:0] S_RD_WAIT = 5'd1;
   localparam logic [4:0] F_ENTRY   = 5'd2;
   localparam logic [4:0] F_MRD     = 5'd3;
   localparam logic [4:0] F_MMUL    = 5'd4;
   localparam logic [4:0] F_MACC    = 5'd5;
   localparam logic [4:0] F_FIN_RD  = 5'd6;
   localparam logic [4:0] F_FIN     = 5'd7;
   localparam logic [4:0] F_CHK     = 5'd8;
   localparam logic [4:0] F_WAIT    = 5'd9;
   localparam logic [4:0] I_ENTRY   = 5'd10;
   localparam logic [4:0] I_MRD     = 5'd11;
   localparam logic [4:0] I_MMUL    = 5'd12;
   localparam logic [4:0] I_MACC    = 5'd13;
   localparam logic [4:0] I_FIN_RD  = 5'd14;
   localparam logic [4:0] I_FIN     = 5'd15;
   localparam logic [4:0] I_CHK     = 5'd16;
   localparam logic [4:0] I_WAIT    = 5'd17;
   localparam logic [4:0] S_DONE    = 5'd18;

   logic [4:0]          state_ff, state_in;
   logic [IW-1:0]       i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic [STATUS_W-1:0] code_ff, code_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [SIZE_W-1:0]   size_ff;
   logic                cinv_ff;

   logic [SIZE_W-1:0]   n_use;
   logic                in_range;
   logic                accept;
   logic                is_diag, upper, last_i, last_j;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SIZE_RESET;
         cinv_ff <= 1'b1;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_MATRIX_SIZE: size_ff <= csr_data;
            CSR_COMPUTE_INV: cinv_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   assign n_use    = (int'(size_ff) > MAX_ORDER) ? SIZE_W'(MAX_ORDER) : size_ff;
   assign in_range = (int'(req_row) < int'(n_use)) && (int'(req_col) < int'(n_use));
   assign req_stall = (state_ff != S_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept  = req_valid && !req_stall;
   assign is_diag = i_ff == j_ff;
   assign upper   = int'(j_ff) > int'(i_ff);
   assign last_i  = int'(i_ff) == int'(n_use) - 1;
   assign last_j  = int'(j_ff) == int'(n_use) - 1;

   // store addresses
   always_comb begin
      if (state_ff == S_IDLE) begin
         fa_row = IW'(req_row);
         fa_col = IW'(req_col);
         iv_row = IW'(req_row);
         iv_col = IW'(req_col);
         wr_row = IW'(req_row);
         wr_col = IW'(req_col);
      end else begin
         fa_row = i_ff;
         fa_col = k_ff;
         iv_row = k_ff;
         iv_col = j_ff;
         wr_row = i_ff;
         wr_col = j_ff;
      end
      if (state_ff == F_FIN_RD) begin
         fb_row = j_ff;
         fb_col = j_ff;
      end else if (state_ff == I_FIN_RD) begin
         fb_row = i_ff;
         fb_col = i_ff;
      end else begin
         fb_row = is_diag ? i_ff : j_ff;
         fb_col = k_ff;
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      code_in      = code_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_type)
                  REQ_LOAD: begin
                     cmd.in_we    = in_range;
                     cmd.rsp_zero = 1'b1;
                     rsp_valid_in = 1'b1;
                  end
                  REQ_COMPUTE: begin
                     code_in = ST_OK;
                     i_in    = '0;
                     j_in    = '0;
                     state_in = (n_use == '0) ? S_DONE : F_ENTRY;
                  end
                  REQ_READ: begin
                     cmd.rd_capture = 1'b1;
                     cmd.rd_ok      = in_range && (req_col <= req_row);
                     state_in       = S_RD_WAIT;
                  end
                  REQ_NOP: begin
                     cmd.rsp_zero = 1'b1;
                     rsp_valid_in = 1'b1;
                  end
                  default: ;
               endcase
            end
         end

         S_RD_WAIT: begin
            cmd.rsp_read = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end

         // factor phase, row by row
         F_ENTRY: begin
            if (upper) begin
               cmd.fac_we   = 1'b1;
               cmd.fac_zero = 1'b1;
            end else begin
               cmd.acc_clr = 1'b1;
               k_in        = '0;
               state_in    = ((is_diag ? i_ff : j_ff) == '0) ? F_FIN_RD : F_MRD;
            end
         end
         F_MRD:  state_in = F_MMUL;
         F_MMUL: begin
            cmd.mul_en = 1'b1;
            state_in   = F_MACC;
         end
         F_MACC: begin
            cmd.acc_en = 1'b1;
            if (int'(k_ff) + 1 == (is_diag ? int'(i_ff) : int'(j_ff))) begin
               state_in = F_FIN_RD;
            end else begin
               k_in     = k_ff + IW'(1);
               state_in = F_MRD;
            end
         end
         F_FIN_RD: state_in = F_FIN;
         F_FIN: begin
            cmd.fin_fac = 1'b1;
            state_in    = F_CHK;
         end
         F_CHK: begin
            if (is_diag) begin
               if (sts.d_le0) begin
                  code_in  = ST_NOT_POS;
                  state_in = S_DONE;
               end else begin
                  cmd.sqrt_start = 1'b1;
                  state_in       = F_WAIT;
               end
            end else begin
               if (sts.piv_zero) begin
                  code_in  = ST_ZERO_DIV;
                  state_in = S_DONE;
               end else begin
                  cmd.div_start = 1'b1;
                  state_in      = F_WAIT;
               end
            end
         end
         F_WAIT: begin
            if (is_diag ? sts.sqrt_done : sts.div_done) begin
               cmd.fac_we        = 1'b1;
               cmd.fac_from_sqrt = is_diag;
               state_in          = F_ENTRY;
            end
         end

         // inverse phase, row by row, columns from right to left
         I_ENTRY: begin
            if (upper) begin
               cmd.inv_we   = 1'b1;
               cmd.inv_zero = 1'b1;
            end else begin
               cmd.acc_clr = 1'b1;
               k_in        = j_ff;
               state_in    = is_diag ? I_FIN_RD : I_MRD;
            end
         end
         I_MRD:  state_in = I_MMUL;
         I_MMUL: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_inv = 1'b1;
            state_in    = I_MACC;
         end
         I_MACC: begin
            cmd.acc_en = 1'b1;
            if (int'(k_ff) + 1 == int'(i_ff)) begin
               state_in = I_FIN_RD;
            end else begin
               k_in     = k_ff + IW'(1);
               state_in = I_MRD;
            end
         end
         I_FIN_RD: state_in = I_FIN;
         I_FIN: begin
            cmd.fin_inv  = 1'b1;
            cmd.fin_diag = is_diag;
            state_in     = I_CHK;
         end
         I_CHK: begin
            if (sts.piv_zero) begin
               code_in  = ST_ZERO_DIV;
               state_in = S_DONE;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = I_WAIT;
            end
         end
         I_WAIT: begin
            if (sts.div_done) begin
               cmd.inv_we = 1'b1;
               state_in   = I_ENTRY;
            end
         end

         S_DONE: begin
            cmd.status_we   = 1'b1;
            cmd.status_code = code_ff;
            cmd.rsp_zero    = 1'b1;
            rsp_valid_in    = 1'b1;
            state_in        = S_IDLE;
         end

         default: state_in = S_IDLE;
      endcase

      // step to the next entry once the current one is written
      if (cmd.fac_we) begin
         if (last_j) begin
            if (last_i) begin
               i_in     = '0;
               j_in     = IW'(int'(n_use) - 1);
               state_in = cinv_ff ? I_ENTRY : S_DONE;
            end else begin
               i_in     = i_ff + IW'(1);
               j_in     = '0;
               state_in = F_ENTRY;
            end
         end else begin
            j_in     = j_ff + IW'(1);
            state_in = F_ENTRY;
         end
      end
      if (cmd.inv_we) begin
         if (j_ff == '0) begin
            if (last_i) begin
               state_in = S_DONE;
            end else begin
               i_in     = i_ff + IW'(1);
               j_in     = IW'(int'(n_use) - 1);
               state_in = I_ENTRY;
            end
         end else begin
            j_in     = j_ff - IW'(1);
            state_in = I_ENTRY;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         code_ff      <= ST_OK;
         i_ff         <= '0;
         j_ff         <= '0;
         k_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         code_ff      <= code_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         k_ff         <= k_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
